@@ rtl/mkn_pkg.sv @@
// Package: shared types, codes and constants of the MAC keyed node table.
package mkn_pkg;

    localparam int SlotCountDef = 16;
    localparam logic [31:0] TimeoutReset = 32'd30000;

    typedef enum logic [2:0] {
        FN_REGISTER  = 3'd0,
        FN_HEARTBEAT = 3'd1,
        FN_SET_STATE = 3'd2,
        FN_REMOVE    = 3'd3,
        FN_OFFLINE   = 3'd4,
        FN_READ_SLOT = 3'd5,
        FN_TICK      = 3'd6,
        FN_LOOKUP    = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_NEW      = 2'd0,
        ST_EXISTING = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [47:0] mac_key;
        logic [6:0]  node_id;
        logic [5:0]  slot_index;
        logic [7:0]  node_kind;
        logic [15:0] battery_mv;
        logic        new_state;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [6:0]  result_id;
        logic        is_offline;
        logic        entry_paired;
        logic [47:0] entry_mac;
        logic [7:0]  entry_kind;
        logic [15:0] entry_battery_mv;
        logic        entry_state;
        logic [31:0] entry_last_seen;
        logic [6:0]  paired_total;
    } t_rsp;

endpackage

@@ rtl/mkn_cmd_fifo.sv @@
// Command queue: short FIFO between the front end and the table engine.
module mkn_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  mkn_pkg::t_cmd i_wr_cmd,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output mkn_pkg::t_cmd o_rd_cmd
);
    import mkn_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_cmd   = r_mem[r_rp];
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue count overflow");

    property p_count_track;
        @(posedge i_clk) disable iff (!i_rst_n)
            (w_wr && !w_rd) |=> (r_cnt == $past(r_cnt) + 2'd1);
    endproperty
    a_count_track: assert property (p_count_track) else $error("queue count lost a push");

    property p_empty_read;
        @(posedge i_clk) disable iff (!i_rst_n) (r_cnt == 2'd0) |-> !w_rd;
    endproperty
    a_empty_read: assert property (p_empty_read) else $error("read from empty queue");
endmodule

@@ rtl/mkn_engine.sv @@
// Table engine: slot memories, scan sequencer and result register.
module mkn_engine #(
    parameter int SLOT_COUNT = mkn_pkg::SlotCountDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  mkn_pkg::t_cmd i_cmd,
    input  logic [31:0]   i_timeout,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output mkn_pkg::t_rsp o_rsp
);
    import mkn_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_EXEC, S_RESP} t_state;

    logic [47:0] r_mac   [SLOT_COUNT];
    logic [7:0]  r_kind  [SLOT_COUNT];
    logic [15:0] r_batt  [SLOT_COUNT];
    logic        r_st    [SLOT_COUNT];
    logic [31:0] r_seen  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_paired;

    t_state      r_state;
    t_cmd        r_cmd;
    logic [CW-1:0] r_idx;
    logic        r_hit, r_free_ok;
    logic [SW-1:0] r_hit_slot, r_free_slot, r_slot;
    logic        r_slot_ok;
    logic [47:0] r_rd_mac;
    logic [7:0]  r_rd_kind;
    logic [15:0] r_rd_batt;
    logic        r_rd_st;
    logic [31:0] r_rd_seen;
    logic [CW-1:0] r_count;
    logic [31:0] r_time;
    t_rsp        r_res;
    t_rsp        r_rsp;
    logic        r_valid;

    logic [SW-1:0] w_scan;
    logic        w_id_ok, w_idx_ok;
    logic [SW-1:0] w_id_slot;
    logic [31:0] w_age;
    logic [SW-1:0] w_slot;
    logic        w_slot_ok;
    t_rsp        w_res;

    assign w_scan    = r_idx[SW-1:0];
    assign w_id_ok   = (r_cmd.node_id != 7'd0) && ({1'b0, r_cmd.node_id} <= 8'(SLOT_COUNT));
    assign w_id_slot = SW'(r_cmd.node_id - 7'd1);
    assign w_idx_ok  = {2'b0, r_cmd.slot_index} < 8'(SLOT_COUNT);
    assign w_age     = r_time - r_rd_seen;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_valid;
    assign o_rsp       = r_rsp;

    // Slot picked for the command once the scan is over.
    always_comb begin
        unique case (r_cmd.func)
            FN_REGISTER: begin
                w_slot    = r_hit ? r_hit_slot : r_free_slot;
                w_slot_ok = r_hit || r_free_ok;
            end
            FN_LOOKUP: begin
                w_slot    = r_hit_slot;
                w_slot_ok = r_hit;
            end
            FN_READ_SLOT: begin
                w_slot    = SW'(r_cmd.slot_index);
                w_slot_ok = w_idx_ok && r_paired[SW'(r_cmd.slot_index)];
            end
            FN_TICK: begin
                w_slot    = '0;
                w_slot_ok = 1'b1;
            end
            default: begin
                w_slot    = w_id_slot;
                w_slot_ok = w_id_ok && r_paired[w_id_slot];
            end
        endcase
    end

    // Result word of the command in S_EXEC.
    always_comb begin
        w_res = '0;
        w_res.status = r_slot_ok ? ST_EXISTING : ST_NOTFOUND;
        w_res.result_id = r_slot_ok ? 7'(r_slot) + 7'd1 : 7'd0;
        w_res.paired_total = 7'(r_count);
        unique case (r_cmd.func)
            FN_REGISTER: begin
                if (!r_slot_ok) begin
                    w_res.status = ST_FULL;
                end else if (!r_hit) begin
                    w_res.status = ST_NEW;
                    w_res.paired_total = 7'(r_count + CW'(1));
                end
            end
            FN_REMOVE: begin
                if (r_slot_ok) begin
                    w_res.paired_total = 7'(r_count - CW'(1));
                end
            end
            FN_OFFLINE: begin
                w_res.is_offline = !r_slot_ok || (w_age > i_timeout);
            end
            FN_READ_SLOT: begin
                if (r_slot_ok) begin
                    w_res.entry_paired     = 1'b1;
                    w_res.entry_mac        = r_rd_mac;
                    w_res.entry_kind       = r_rd_kind;
                    w_res.entry_battery_mv = r_rd_batt;
                    w_res.entry_state      = r_rd_st;
                    w_res.entry_last_seen  = r_rd_seen;
                end
            end
            FN_TICK: begin
                w_res.status = ST_EXISTING;
                w_res.result_id = 7'd0;
            end
            default: ;
        endcase
    end

    // Slot memories read through a registered port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_mac  <= r_mac[w_slot];
            r_rd_kind <= r_kind[w_slot];
            r_rd_batt <= r_batt[w_slot];
            r_rd_st   <= r_st[w_slot];
            r_rd_seen <= r_seen[w_slot];
        end
        if (r_state == S_EXEC && r_slot_ok) begin
            unique case (r_cmd.func)
                FN_REGISTER: begin
                    r_seen[r_slot] <= r_time;
                    r_batt[r_slot] <= r_cmd.battery_mv;
                    if (!r_hit) begin
                        r_mac[r_slot]  <= r_cmd.mac_key;
                        r_kind[r_slot] <= r_cmd.node_kind;
                        r_st[r_slot]   <= 1'b0;
                    end
                end
                FN_HEARTBEAT: begin
                    r_seen[r_slot] <= r_time;
                    r_batt[r_slot] <= r_cmd.battery_mv;
                end
                FN_SET_STATE: begin
                    r_seen[r_slot] <= r_time;
                    r_st[r_slot]   <= r_cmd.new_state;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_paired <= '0;
            r_count  <= '0;
            r_time   <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (r_state == S_RESP && (!r_valid || i_rsp_ready)) begin
                r_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state <= (i_cmd.func == FN_REGISTER || i_cmd.func == FN_LOOKUP)
                                   ? S_SCAN : S_READ;
                    end
                end
                S_SCAN: begin
                    // one slot per cycle: first MAC hit, first free slot
                    if (r_paired[w_scan] && r_mac[w_scan] == r_cmd.mac_key && !r_hit) begin
                        r_hit <= 1'b1;
                        r_hit_slot <= w_scan;
                    end
                    if (!r_paired[w_scan] && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free_slot <= w_scan;
                    end
                    r_idx <= r_idx + CW'(1);
                    if (r_idx == CW'(SLOT_COUNT - 1)) r_state <= S_READ;
                end
                S_READ: begin
                    r_slot    <= w_slot;
                    r_slot_ok <= w_slot_ok;
                    r_state   <= S_EXEC;
                end
                S_EXEC: begin
                    r_res <= w_res;
                    unique case (r_cmd.func)
                        FN_REGISTER: begin
                            if (r_slot_ok && !r_hit) begin
                                r_paired[r_slot] <= 1'b1;
                                r_count <= r_count + CW'(1);
                            end
                        end
                        FN_REMOVE: begin
                            if (r_slot_ok) begin
                                r_paired[r_slot] <= 1'b0;
                                r_count <= r_count - CW'(1);
                            end
                        end
                        FN_TICK: begin
                            r_time <= r_time + 32'd1;
                        end
                        default: ;
                    endcase
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    // wait until the result register is free
                    if (!r_valid || i_rsp_ready) begin
                        r_rsp   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // r_res is loaded in S_EXEC and moves to r_rsp when S_RESP finds the output free
    property p_count_match;
        @(posedge i_clk) disable iff (!i_rst_n) r_count == CW'($countones(r_paired));
    endproperty
    a_count_match: assert property (p_count_match) else $error("paired count drift");

    property p_busy_not_ready;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state != S_IDLE) |-> !o_cmd_ready;
    endproperty
    a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");

    property p_tick_advance;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_EXEC && r_cmd.func == FN_TICK) |=> r_time == $past(r_time) + 32'd1;
    endproperty
    a_tick_advance: assert property (p_tick_advance) else $error("tick lost");
endmodule

@@ rtl/mac_keyed_node_table_with_aging_unit.sv @@
// Top level: MAC keyed node table with aging, stream ports and timeout register.
// The block keeps SLOT_COUNT node slots keyed by 48-bit MAC address and answers
// one result word for every command word. Register and lookup scan the slots one
// per cycle in S_SCAN before S_READ, S_EXEC and S_RESP; all id and slot based
// operations go straight to S_READ. The scan over the slot MAC
// memory sets the rate. A two-deep command queue between the front end and the
// table engine lets a new word be taken while a result waits on the output.
// Tick advances the internal 32-bit millisecond clock; a node is offline when
// the wrapped age exceeds the timeout register (reset 30000). Write the timeout
// only while the block is idle.
module mac_keyed_node_table_with_aging_unit #(
    parameter int SLOT_COUNT = mkn_pkg::SlotCountDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: mac_key[47:0], node_id[54:48], slot_index[60:55], node_kind[68:61],
    //        battery_mv[84:69], new_state[85], zero[87:86]
    input  logic [87:0]  s_axis_tdata,
    // tuser: func[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: status[1:0], result_id[8:2], is_offline[9], entry_paired[10],
    //        entry_mac[58:11], entry_kind[66:59], entry_battery_mv[82:67],
    //        entry_state[83], entry_last_seen[115:84], paired_total[122:116], zero[127:123]
    output logic [127:0] m_axis_tdata
);
    import mkn_pkg::*;

    logic [31:0] r_timeout;
    t_cmd        w_cmd, w_q_cmd;
    logic        w_q_valid, w_q_ready;
    t_rsp        w_rsp;

    // hold the timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TimeoutReset;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // unpack the command word
    always_comb begin
        w_cmd.func       = t_func'(s_axis_tuser);
        w_cmd.mac_key    = s_axis_tdata[47:0];
        w_cmd.node_id    = s_axis_tdata[54:48];
        w_cmd.slot_index = s_axis_tdata[60:55];
        w_cmd.node_kind  = s_axis_tdata[68:61];
        w_cmd.battery_mv = s_axis_tdata[84:69];
        w_cmd.new_state  = s_axis_tdata[85];
    end

    mkn_cmd_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_valid(s_axis_tvalid), .o_wr_ready(s_axis_tready), .i_wr_cmd(w_cmd),
        .o_rd_valid(w_q_valid), .i_rd_ready(w_q_ready), .o_rd_cmd(w_q_cmd)
    );

    mkn_engine #(.SLOT_COUNT(SLOT_COUNT)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_q_valid), .o_cmd_ready(w_q_ready), .i_cmd(w_q_cmd),
        .i_timeout(r_timeout),
        .o_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready), .o_rsp(w_rsp)
    );

    // pack the result word
    assign m_axis_tdata = {5'd0, w_rsp.paired_total, w_rsp.entry_last_seen,
                           w_rsp.entry_state, w_rsp.entry_battery_mv, w_rsp.entry_kind,
                           w_rsp.entry_mac, w_rsp.entry_paired, w_rsp.is_offline,
                           w_rsp.result_id, w_rsp.status};
endmodule
